@@ hdl/drd_pkg.sv @@
package drd_pkg;

  localparam int DEF_MAX_CLASSES = 256;
  localparam int DEF_MAX_ROWS    = 32768;
  localparam int BOX_ELEMS       = 5;
  localparam int ROW_OUT_W       = 15;
  localparam int CLASS_OUT_W     = 8;
  localparam int COORD_W         = 16;
  localparam int CONF_W          = 17;
  localparam int SCORE_W         = 31;
  localparam int CFG_DATA_W      = 16;
  localparam int CLASS_CFG_W     = 9;

  localparam logic [CONF_W-1:0] CONF_ONE = 17'd65536;

  typedef enum logic [0:0] {
    CFG_CLASS_COUNT     = 1'b0,
    CFG_SCORE_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0]      row;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] h;
    logic [CLASS_OUT_W-1:0]    cls;
    logic [SCORE_W-1:0]        obj;
    logic [SCORE_W-1:0]        score;
  } drd_cand_t;

  // Q16.16 to integer pixels, truncated toward zero
  function automatic logic signed [COORD_W-1:0] trunc_q16(input logic signed [31:0] v);
    logic [31:0] mag;
    logic [15:0] q;
    mag = v[31] ? (32'd0 - v) : v;
    q   = mag[31:16];
    return v[31] ? (16'd0 - q) : q;
  endfunction

  // center minus half size (halving toward zero), saturated to 16 bits
  function automatic logic signed [COORD_W-1:0] box_edge(
    input logic signed [COORD_W-1:0] c,
    input logic signed [COORD_W-1:0] s
  );
    logic signed [17:0] c_ext;
    logic signed [17:0] s_ext;
    logic signed [17:0] half;
    logic signed [17:0] diff;
    c_ext = 18'(c);
    s_ext = 18'(s);
    half  = (s_ext + (s[15] ? 18'sd1 : 18'sd0)) >>> 1;
    diff  = c_ext - half;
    if (diff > 18'sd32767) begin
      return 16'sh7fff;
    end else if (diff < -18'sd32768) begin
      return 16'sh8000;
    end
    return diff[15:0];
  endfunction

endpackage

@@ hdl/drd_decode.sv @@
module drd_decode #(
  parameter int MAX_CLASSES = drd_pkg::DEF_MAX_CLASSES,
  parameter int MAX_ROWS    = drd_pkg::DEF_MAX_ROWS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                word_go,
  input  logic signed [31:0]                  word_value,
  input  logic                                word_first,
  input  logic [drd_pkg::CLASS_CFG_W-1:0]     class_count,
  input  logic [drd_pkg::CFG_DATA_W-1:0]      score_threshold,
  input  logic                                cand_pop,
  output logic                                cand_valid,
  output drd_pkg::drd_cand_t                  cand
);
  import drd_pkg::*;

  localparam int POS_W = $clog2(MAX_CLASSES + BOX_ELEMS);
  localparam int CMP_W = ((POS_W > CLASS_CFG_W) ? POS_W : CLASS_CFG_W) + 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [POS_W-1:0]          pos;
  logic [ROW_W-1:0]          row;
  logic signed [COORD_W-1:0] box [4];
  logic signed [31:0]        obj;
  logic signed [31:0]        best;
  logic [CLASS_OUT_W-1:0]    best_cls;

  logic [POS_W-1:0]          pos_cur;
  logic [ROW_W-1:0]          row_cur;
  logic [ROW_W-1:0]          row_wrap;
  logic [CMP_W-1:0]          cc_ext;
  logic [CMP_W-1:0]          classes;
  logic [CMP_W-1:0]          last;
  logic                      is_last;
  logic                      is_score;
  logic                      beat;
  logic [POS_W-1:0]          cls_diff;
  logic [POS_W+CLASS_OUT_W-1:0] cls_wide;
  logic [ROW_W+ROW_OUT_W-1:0]   row_wide;
  logic signed [31:0]        best_now;
  logic [CLASS_OUT_W-1:0]    cls_now;
  logic                      emit;
  logic signed [31:0]        thr_ext;

  always_comb begin
    pos_cur  = word_first ? '0 : pos;
    row_cur  = word_first ? '0 : row;
    row_wrap = (row_cur == ROW_W'(MAX_ROWS - 1)) ? '0 : row_cur + ROW_W'(1);
    cc_ext   = CMP_W'(class_count);
    if (cc_ext == '0) begin
      classes = CMP_W'(1);
    end else if (cc_ext > CMP_W'(MAX_CLASSES)) begin
      classes = CMP_W'(MAX_CLASSES);
    end else begin
      classes = cc_ext;
    end
    last     = classes + CMP_W'(BOX_ELEMS - 1);
    is_last  = CMP_W'(pos_cur) >= last;
    is_score = pos_cur >= POS_W'(BOX_ELEMS);
    beat     = word_value > best;
    cls_diff = pos_cur - POS_W'(BOX_ELEMS);
    cls_wide = {{CLASS_OUT_W{1'b0}}, cls_diff};
    row_wide = {{ROW_OUT_W{1'b0}}, row_cur};
    best_now = (is_score && beat) ? word_value : best;
    cls_now  = (is_score && beat) ? cls_wide[CLASS_OUT_W-1:0] : best_cls;
    thr_ext  = {16'd0, score_threshold};
    emit     = is_last && (obj > thr_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      row      <= '0;
      box[0]   <= '0;
      box[1]   <= '0;
      box[2]   <= '0;
      box[3]   <= '0;
      obj      <= '0;
      best     <= '0;
      best_cls <= '0;
    end else if (word_go) begin
      pos <= is_last ? '0 : pos_cur + POS_W'(1);
      row <= is_last ? row_wrap : row_cur;
      for (int i = 0; i < 4; i++) begin
        if (pos_cur == POS_W'(i)) begin
          box[i] <= trunc_q16(word_value);
        end
      end
      if (pos_cur == POS_W'(BOX_ELEMS - 1)) begin
        obj      <= word_value;
        best     <= '0;
        best_cls <= '0;
      end else if (is_score) begin
        best     <= best_now;
        best_cls <= cls_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else if (word_go) begin
      cand_valid <= emit;
    end else if (cand_pop) begin
      cand_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word_go && emit) begin
      cand.row   <= row_wide[ROW_OUT_W-1:0];
      cand.cx    <= box[0];
      cand.cy    <= box[1];
      cand.w     <= box[2];
      cand.h     <= box[3];
      cand.cls   <= cls_now;
      cand.obj   <= obj[SCORE_W-1:0];
      cand.score <= best_now[SCORE_W-1:0];
    end
  end

endmodule

@@ hdl/drd_score.sv @@
module drd_score (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cand_valid,
  input  drd_pkg::drd_cand_t                   cand,
  output logic                                 cand_pop,
  output logic                                 det_valid,
  input  logic                                 det_stall,
  output logic [drd_pkg::ROW_OUT_W-1:0]        row_index,
  output logic signed [drd_pkg::COORD_W-1:0]   box_left,
  output logic signed [drd_pkg::COORD_W-1:0]   box_top,
  output logic signed [drd_pkg::COORD_W-1:0]   box_width,
  output logic signed [drd_pkg::COORD_W-1:0]   box_height,
  output logic [drd_pkg::CLASS_OUT_W-1:0]      class_index,
  output logic [drd_pkg::CONF_W-1:0]           confidence
);
  import drd_pkg::*;

  logic [2*SCORE_W-1:0] prod;
  logic [2*SCORE_W-17:0] conf_raw;
  logic [CONF_W-1:0]    conf;

  always_comb begin
    cand_pop = cand_valid && (!det_valid || !det_stall);
    prod     = cand.obj * cand.score;
    conf_raw = prod[2*SCORE_W-1:16];
    conf     = (conf_raw > (2*SCORE_W-16)'(CONF_ONE)) ? CONF_ONE : conf_raw[CONF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      det_valid <= 1'b0;
    end else if (cand_pop) begin
      det_valid <= 1'b1;
    end else if (!det_stall) begin
      det_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_pop) begin
      row_index   <= cand.row;
      box_left    <= box_edge(cand.cx, cand.w);
      box_top     <= box_edge(cand.cy, cand.h);
      box_width   <= cand.w;
      box_height  <= cand.h;
      class_index <= cand.cls;
      confidence  <= conf;
    end
  end

endmodule

@@ hdl/detector_row_decode_top.sv @@
// A detection moves from the input register to the candidate register, then
// to the output register. Throughput: one word per cycle; each register holds
// one entry; the input stalls only when all are full and det_stall is high.
// Reset (rst, synchronous): clears row and position counters, box and score
// state, valid flags, and loads class_count = 80, score_threshold = 16384.
module detector_row_decode_top #(
  parameter int MAX_CLASSES = drd_pkg::DEF_MAX_CLASSES,
  parameter int MAX_ROWS    = drd_pkg::DEF_MAX_ROWS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  drd_pkg::cfg_reg_t                    cfg_index,
  input  logic [drd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 elem_valid,
  output logic                                 elem_stall,
  input  logic signed [31:0]                   element_value,
  input  logic                                 tensor_start,
  output logic                                 det_valid,
  input  logic                                 det_stall,
  output logic [drd_pkg::ROW_OUT_W-1:0]        row_index,
  output logic signed [drd_pkg::COORD_W-1:0]   box_left,
  output logic signed [drd_pkg::COORD_W-1:0]   box_top,
  output logic signed [drd_pkg::COORD_W-1:0]   box_width,
  output logic signed [drd_pkg::COORD_W-1:0]   box_height,
  output logic [drd_pkg::CLASS_OUT_W-1:0]      class_index,
  output logic [drd_pkg::CONF_W-1:0]           confidence
);
  import drd_pkg::*;

  logic [CLASS_CFG_W-1:0] class_count;
  logic [CFG_DATA_W-1:0]  score_threshold;

  logic                   s0_valid;
  logic signed [31:0]     s0_value;
  logic                   s0_first;
  logic                   elem_take;
  logic                   word_go;
  logic                   cand_valid;
  logic                   cand_pop;
  logic                   cand_free;
  drd_cand_t              cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count     <= 9'd80;
      score_threshold <= 16'd16384;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CLASS_COUNT:     class_count     <= cfg_data[CLASS_CFG_W-1:0];
        CFG_SCORE_THRESHOLD: score_threshold <= cfg_data;
      endcase
    end
  end

  always_comb begin
    cand_free  = !cand_valid || cand_pop;
    word_go    = s0_valid && cand_free;
    elem_stall = s0_valid && !cand_free;
    elem_take  = elem_valid && !elem_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (elem_take) begin
      s0_valid <= 1'b1;
    end else if (word_go) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (elem_take) begin
      s0_value <= element_value;
      s0_first <= tensor_start;
    end
  end

  drd_decode #(
    .MAX_CLASSES(MAX_CLASSES),
    .MAX_ROWS   (MAX_ROWS)
  ) u_decode (
    .clk            (clk),
    .rst            (rst),
    .word_go        (word_go),
    .word_value     (s0_value),
    .word_first     (s0_first),
    .class_count    (class_count),
    .score_threshold(score_threshold),
    .cand_pop       (cand_pop),
    .cand_valid     (cand_valid),
    .cand           (cand)
  );

  drd_score u_score (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand       (cand),
    .cand_pop   (cand_pop),
    .det_valid  (det_valid),
    .det_stall  (det_stall),
    .row_index  (row_index),
    .box_left   (box_left),
    .box_top    (box_top),
    .box_width  (box_width),
    .box_height (box_height),
    .class_index(class_index),
    .confidence (confidence)
  );

`ifndef SYNTHESIS
  a_cand_held: assert property (@(posedge clk) disable iff (rst)
    (cand_valid && det_valid && det_stall) |=> cand_valid)
    else $error("pending detection dropped while output stalled");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    elem_stall |-> (s0_valid && cand_valid))
    else $error("input stalled with free pipeline slot");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(det_valid) |-> $past(cand_valid))
    else $error("detection raised without a pending candidate");
`endif

endmodule
